FILE: rtl/core/spbf_pkg.sv
// ----------------------------------------------------------------------------
// spbf_pkg
// Shared constants, register codes and divider handshake types for the
// spectrum peak band feature block.
// ----------------------------------------------------------------------------
package spbf_pkg;

	// bins held in the peak memory
	localparam int NUM_BINS = 256;
	localparam int IDX_W    = $clog2(NUM_BINS);

	// field widths
	localparam int MAG_W = 16;
	localparam int PCT_W = 7;
	localparam int LEN_W = 9;
	localparam int CNT_W = 8;
	localparam int SUM_W = 24;
	localparam int WID_W = 16;

	// frame length compare width, wide enough for the index plus one
	localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

	// decay: floor(x / 100) as (x * RCP) >> RCP_SHIFT, multiplier cut in two halves
	localparam int PROD_W    = MAG_W + PCT_W;
	localparam int RCP_SPLIT = 12;
	localparam int RCP_SHIFT = 30;
	localparam int RPP_W     = PROD_W + RCP_SPLIT;
	localparam int RCP_TOT_W = RPP_W + RCP_SPLIT;
	localparam logic [RCP_SPLIT-1:0] RCP_HI = 12'd2621;
	localparam logic [RCP_SPLIT-1:0] RCP_LO = 12'd1803;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	// threshold compare: peak * 200 >= thr * 32768
	localparam int HIT_W = MAG_W + 8;
	localparam logic [HIT_W-1:0] HIT_SCALE = 24'd200;
	localparam int THR_SHIFT = 15;

	// fraction bits of the width result
	localparam int FRAC_W = 12;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMOOTH = 2'd0,
		REG_THRESH = 2'd1,
		REG_FRAME  = 2'd2
	} cfg_reg_t;

	localparam logic [LEN_W-1:0] FRAME_RESET = 9'd256;

	typedef struct packed {
		logic             go;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] hits;
		logic [MAG_W-1:0] maxv;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [WID_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: rtl/core/spbf_div.sv
// ----------------------------------------------------------------------------
// spbf_div
// Bit-serial band width divider: floor(sum * 4096 / (max * hits)),
// saturated to 16 bits, zero when hits is zero.
// ----------------------------------------------------------------------------
module spbf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  spbf_pkg::div_req_t  req,
	output spbf_pkg::div_rsp_t  rsp
);
	import spbf_pkg::*;

	localparam int QCNT_W = $clog2(WID_W);
	localparam int CHK_W  = SUM_W + 4;

	typedef enum logic [1:0] {D_IDLE, D_MUL, D_CHK, D_RUN} dstate_t;

	dstate_t            state_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   hits_q;
	logic [MAG_W-1:0]   max_q;
	logic [SUM_W-1:0]   dvs_q;
	logic [SUM_W-1:0]   rem_q;
	logic [WID_W-1:0]   num_q;
	logic [WID_W-1:0]   quot_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               done_q;

	logic [SUM_W:0]     trial;
	logic               fits;
	logic               sat;

	assign trial = {rem_q, num_q[WID_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	// quotient overflows 16 bits exactly when sum >= 16 * divisor
	assign sat   = CHK_W'(sum_q) >= {dvs_q, 4'b0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.go) begin
						sum_q   <= req.sum;
						hits_q  <= req.hits;
						max_q   <= req.maxv;
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					dvs_q   <= SUM_W'(max_q) * SUM_W'(hits_q);
					state_q <= D_CHK;
				end
				D_CHK: begin
					priority if (hits_q == '0) begin
						quot_q  <= '0;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else if (sat) begin
						quot_q  <= '1;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						// upper bits of sum<<12 already sit below the divisor
						rem_q   <= SUM_W'(sum_q[SUM_W-1:4]);
						num_q   <= {sum_q[3:0], {FRAC_W{1'b0}}};
						quot_q  <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (fits) begin
						rem_q  <= SUM_W'(trial - {1'b0, dvs_q});
						quot_q <= {quot_q[WID_W-2:0], 1'b1};
					end else begin
						rem_q  <= trial[SUM_W-1:0];
						quot_q <= {quot_q[WID_W-2:0], 1'b0};
					end
					num_q <= {num_q[WID_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == QCNT_W'(WID_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: rtl/core/spectrum_peak_band_features.sv
// ----------------------------------------------------------------------------
// spectrum_peak_band_features
// Per-bin peak hold with decay, frame maximum, and lower/upper half band
// hit counts and mean normalized peak width.
// ----------------------------------------------------------------------------
// Usage: pulse start with bin_magnitude while busy is low; the bin is taken at
// that edge while the single-port peak memory is read; busy stays high through
// the decay multiply (two partial products), write-back and accumulate steps,
// so no new bin is taken before the last is through. On the last bin of a
// frame, if the frame maximum is nonzero, two bit-serial divisions (one per
// half, 16 steps each) keep busy high; then done pulses for one cycle with
// lower_count, lower_width, upper_count and upper_width. No back-pressure:
// done is not held and the outputs hold only until the next frame end. The
// peak memory needs no clearing pass after reset; a bank of per-entry valid
// bits makes unwritten entries read as zero. Configuration (cfg_we, cfg_index,
// cfg_data) must be written only while busy is low, which the block does not
// enforce; index 0 is smoothing percent, 1 threshold percent, 2 frame length.
// ----------------------------------------------------------------------------
module spectrum_peak_band_features (
	input  logic                            clk,
	input  logic                            arst_n,
	// bin beat
	input  logic                            start,
	output logic                            busy,
	input  logic [spbf_pkg::MAG_W-1:0]      bin_magnitude,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [spbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spbf_pkg::LEN_W-1:0]      cfg_data,
	// result beat
	output logic                            done,
	output logic [spbf_pkg::CNT_W-1:0]      lower_count,
	output logic [spbf_pkg::WID_W-1:0]      lower_width,
	output logic [spbf_pkg::CNT_W-1:0]      upper_count,
	output logic [spbf_pkg::WID_W-1:0]      upper_width
);
	import spbf_pkg::*;

	// per-bin flow: take bin and read memory, form peak*(100-s), split
	// reciprocal products, update and write peak, accumulate; frame end adds
	// the two band divisions
	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_RCP, S_UPD, S_ACC, S_DIVL, S_DIVU
	} state_t;

	state_t state_q;

	// configuration registers
	logic [PCT_W-1:0] smooth_q;
	logic [PCT_W-1:0] thresh_q;
	logic [LEN_W-1:0] frame_q;

	// frame state
	logic [IDX_W-1:0] idx_q;
	logic [MAG_W-1:0] fmax_q;
	logic [CNT_W-1:0] lo_hits_q;
	logic [CNT_W-1:0] up_hits_q;
	logic [SUM_W-1:0] lo_sum_q;
	logic [SUM_W-1:0] up_sum_q;

	// peak memory, sync read, plus valid bits so reset reads as zero
	logic [MAG_W-1:0]    peak_mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic [MAG_W-1:0]    rd_data_s1;
	logic                rd_vld_s1;
	logic [MAG_W-1:0]    mag_s1;

	// decay datapath
	logic [PROD_W-1:0] prod_s2;
	logic [RPP_W-1:0]  rcp_hi_s3;
	logic [RPP_W-1:0]  rcp_lo_s3;
	logic [MAG_W-1:0]  peak_s4;

	// frame-end results waiting on the divider
	logic [SUM_W-1:0] fin_lo_sum_q;
	logic [SUM_W-1:0] fin_up_sum_q;
	logic [MAG_W-1:0] fin_max_q;
	logic             div_go_q;

	// result registers
	logic             done_q;
	logic [CNT_W-1:0] lower_count_q;
	logic [WID_W-1:0] lower_width_q;
	logic [CNT_W-1:0] upper_count_q;
	logic [WID_W-1:0] upper_width_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// combinational helpers
	logic [PCT_W-1:0]     s_eff;
	logic [PCT_W-1:0]     keep_pct;
	logic [CMP_W-1:0]     n_eff;
	logic [CMP_W-1:0]     idx_ext;
	logic [MAG_W-1:0]     old_peak;
	logic [RCP_TOT_W-1:0] rcp_sum;
	logic [MAG_W-1:0]     decayed;
	logic [MAG_W-1:0]     new_peak;
	logic [HIT_W-1:0]     peak_scaled;
	logic [HIT_W-1:0]     thr_scaled;
	logic                 hit;
	logic                 is_upper;
	logic                 is_last;
	logic [SUM_W:0]       lo_sum_add;
	logic [SUM_W:0]       up_sum_add;
	logic [SUM_W-1:0]     lo_sum_nxt;
	logic [SUM_W-1:0]     up_sum_nxt;
	logic [CNT_W-1:0]     lo_hits_nxt;
	logic [CNT_W-1:0]     up_hits_nxt;
	logic                 accept;

	assign accept = (state_q == S_IDLE) && start;
	assign busy   = (state_q != S_IDLE);

	// smoothing above 100 acts as full decay
	assign s_eff    = (smooth_q > PCT_FULL) ? PCT_FULL : smooth_q;
	assign keep_pct = PCT_FULL - s_eff;

	// frame length clamped to 2 .. NUM_BINS
	always_comb begin
		priority if (CMP_W'(frame_q) < CMP_W'(2))
			n_eff = CMP_W'(2);
		else if (CMP_W'(frame_q) > CMP_W'(NUM_BINS))
			n_eff = CMP_W'(NUM_BINS);
		else
			n_eff = CMP_W'(frame_q);
	end

	assign idx_ext  = CMP_W'(idx_q);
	assign is_upper = idx_ext >= (n_eff >> 1);
	// lowering the length mid-frame ends the frame on the current bin
	assign is_last  = (idx_ext + CMP_W'(1)) >= n_eff;

	assign old_peak = rd_vld_s1 ? rd_data_s1 : '0;

	// floor(prod / 100) from the two registered partial products
	assign rcp_sum  = {rcp_hi_s3, {RCP_SPLIT{1'b0}}} + RCP_TOT_W'(rcp_lo_s3);
	assign decayed  = rcp_sum[RCP_SHIFT +: MAG_W];
	assign new_peak = (decayed < mag_s1) ? mag_s1 : decayed;

	assign peak_scaled = HIT_W'(peak_s4) * HIT_SCALE;
	assign thr_scaled  = HIT_W'(thresh_q) << THR_SHIFT;
	assign hit         = peak_scaled >= thr_scaled;

	// saturating accumulators
	assign lo_sum_add = {1'b0, lo_sum_q} + (SUM_W+1)'(peak_s4);
	assign up_sum_add = {1'b0, up_sum_q} + (SUM_W+1)'(peak_s4);

	always_comb begin
		lo_sum_nxt  = lo_sum_q;
		up_sum_nxt  = up_sum_q;
		lo_hits_nxt = lo_hits_q;
		up_hits_nxt = up_hits_q;
		if (hit) begin
			if (is_upper) begin
				up_sum_nxt  = up_sum_add[SUM_W] ? '1 : up_sum_add[SUM_W-1:0];
				up_hits_nxt = (up_hits_q == '1) ? up_hits_q : up_hits_q + 1'b1;
			end else begin
				lo_sum_nxt  = lo_sum_add[SUM_W] ? '1 : lo_sum_add[SUM_W-1:0];
				lo_hits_nxt = (lo_hits_q == '1) ? lo_hits_q : lo_hits_q + 1'b1;
			end
		end
	end

	// peak memory: read on the accept edge, write back once per bin
	always_ff @(posedge clk) begin
		if (accept)
			rd_data_s1 <= peak_mem[idx_q];
		if (state_q == S_UPD)
			peak_mem[idx_q] <= new_peak;
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept)
			mag_s1 <= bin_magnitude;
		if (state_q == S_MUL)
			prod_s2 <= PROD_W'(old_peak) * PROD_W'(keep_pct);
		if (state_q == S_RCP) begin
			rcp_hi_s3 <= RPP_W'(prod_s2) * RPP_W'(RCP_HI);
			rcp_lo_s3 <= RPP_W'(prod_s2) * RPP_W'(RCP_LO);
		end
		if (state_q == S_UPD)
			peak_s4 <= new_peak;
	end

	// config, control, frame state and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			smooth_q      <= '0;
			thresh_q      <= '0;
			frame_q       <= FRAME_RESET;
			idx_q         <= '0;
			fmax_q        <= '0;
			lo_hits_q     <= '0;
			up_hits_q     <= '0;
			lo_sum_q      <= '0;
			up_sum_q      <= '0;
			vld_q         <= '0;
			rd_vld_s1     <= 1'b0;
			div_go_q      <= 1'b0;
			done_q        <= 1'b0;
			lower_count_q <= '0;
			upper_count_q <= '0;
			lower_width_q <= '0;
			upper_width_q <= '0;
			fin_lo_sum_q  <= '0;
			fin_up_sum_q  <= '0;
			fin_max_q     <= '0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_SMOOTH: smooth_q <= cfg_data[PCT_W-1:0];
					REG_THRESH: thresh_q <= cfg_data[PCT_W-1:0];
					REG_FRAME:  frame_q  <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_vld_s1 <= vld_q[idx_q];
						if (bin_magnitude > fmax_q)
							fmax_q <= bin_magnitude;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_RCP;
				S_RCP: state_q <= S_UPD;
				S_UPD: begin
					vld_q[idx_q] <= 1'b1;
					state_q      <= S_ACC;
				end
				S_ACC: begin
					if (is_last) begin
						// frame end: clear running state; with a nonzero maximum, hand sums to divider
						idx_q     <= '0;
						fmax_q    <= '0;
						lo_hits_q <= '0;
						up_hits_q <= '0;
						lo_sum_q  <= '0;
						up_sum_q  <= '0;
						if (fmax_q != '0) begin
							lower_count_q <= lo_hits_nxt;
							upper_count_q <= up_hits_nxt;
							fin_lo_sum_q  <= lo_sum_nxt;
							fin_up_sum_q  <= up_sum_nxt;
							fin_max_q     <= fmax_q;
							div_go_q      <= 1'b1;
							state_q       <= S_DIVL;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						idx_q     <= idx_q + 1'b1;
						lo_hits_q <= lo_hits_nxt;
						up_hits_q <= up_hits_nxt;
						lo_sum_q  <= lo_sum_nxt;
						up_sum_q  <= up_sum_nxt;
						state_q   <= S_IDLE;
					end
				end
				S_DIVL: begin
					if (div_rsp.done) begin
						lower_width_q <= div_rsp.quot;
						div_go_q      <= 1'b1;
						state_q       <= S_DIVU;
					end
				end
				S_DIVU: begin
					if (div_rsp.done) begin
						upper_width_q <= div_rsp.quot;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider operands follow the half being worked on
	always_comb begin
		div_req.go   = div_go_q;
		div_req.maxv = fin_max_q;
		if (state_q == S_DIVU) begin
			div_req.sum  = fin_up_sum_q;
			div_req.hits = upper_count_q;
		end else begin
			div_req.sum  = fin_lo_sum_q;
			div_req.hits = lower_count_q;
		end
	end

	spbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign done        = done_q;
	assign lower_count = lower_count_q;
	assign lower_width = lower_width_q;
	assign upper_count = upper_count_q;
	assign upper_width = upper_width_q;

	// a result beat only follows the upper division
	a_done_after_divu: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DIVU))
		else $error("result beat without upper division");

	// an empty band reports zero width
	a_empty_band: assert property (@(posedge clk) disable iff (!arst_n)
		(done && lower_count == '0) |-> lower_width == '0)
		else $error("lower band empty but width nonzero");

	// divider answers only while the block waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIVL || state_q == S_DIVU))
		else $error("divider done outside a division state");

	// a new bin is never taken during a frame-end division
	a_no_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVL || state_q == S_DIVU) |-> busy)
		else $error("bin accepted during division");

endmodule
